### hdl/sha256_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// sha256_stream_hasher_defines
// assertion macros shared by the hasher rtl
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expression holds on every clock edge out of reset
`define SHA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("sha assertion failed");

// consequent holds in the same cycle as the antecedent
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sha assertion failed");

// consequent holds in the cycle after the antecedent
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sha assertion failed");

`else

`define SHA_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// types and constants of the streaming sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

    // input transfer: one message byte and its flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    // output transfer: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // eight 32-bit words: chain value or working variables a..h
    typedef logic [7:0][31:0] t_words8;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic load;     // copy chain value into working variables
        logic round;    // run one compression round
        logic push;     // shift a message word into the schedule window
    } t_core_ctrl;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FINISH,
        S_OUT
    } t_state;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd55;   // next byte lands at offset 56
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam t_words8 HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [63:0][31:0] ROUND_K = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

endpackage

### hdl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// sha-256 round unit: rolling 16-word schedule window and working
// variables, one round per cycle
// ----------------------------------------------------------------------------
module sha_core (
    input  logic                 i_clk,
    input  sha_pkg::t_core_ctrl  i_ctrl,
    input  logic [31:0]          i_push_word,
    input  logic [31:0]          i_k,
    input  sha_pkg::t_words8     i_chain,
    output sha_pkg::t_words8     o_vars
);
    import sha_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [15:0][31:0] r_w;
    t_words8           r_vars;

    logic [31:0] sig0, sig1, new_w;
    logic [31:0] big0, big1, choose, major, tmp1, tmp2;
    t_words8     n_vars;

    // next schedule word from the window taps
    always_comb begin
        sig0  = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        sig1  = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        new_w = r_w[0] + sig0 + r_w[9] + sig1;
    end

    // one compression round on a..h
    always_comb begin
        big1   = rotr(r_vars[4], 6) ^ rotr(r_vars[4], 11) ^ rotr(r_vars[4], 25);
        choose = (r_vars[4] & r_vars[5]) ^ (~r_vars[4] & r_vars[6]);
        tmp1   = r_vars[7] + big1 + choose + i_k + r_w[0];
        big0   = rotr(r_vars[0], 2) ^ rotr(r_vars[0], 13) ^ rotr(r_vars[0], 22);
        major  = (r_vars[0] & r_vars[1]) ^ (r_vars[0] & r_vars[2]) ^ (r_vars[1] & r_vars[2]);
        tmp2   = big0 + major;
        n_vars    = r_vars;
        n_vars[7] = r_vars[6];
        n_vars[6] = r_vars[5];
        n_vars[5] = r_vars[4];
        n_vars[4] = r_vars[3] + tmp1;
        n_vars[3] = r_vars[2];
        n_vars[2] = r_vars[1];
        n_vars[1] = r_vars[0];
        n_vars[0] = tmp1 + tmp2;
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_vars <= i_chain;
        end else if (i_ctrl.round) begin
            r_vars <= n_vars;
        end
    end

    // schedule window: oldest word at the bottom
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push || i_ctrl.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= i_ctrl.push ? i_push_word : new_w;
        end
    end

    assign o_vars = r_vars;

endmodule

### hdl/sha256_stream_hasher.sv
// message bytes are accepted while idle; a full 64-byte block then runs its
// rounds (one round per cycle on the shared round unit), then the chain update
// closing a message: padding bytes, one or two blocks of rounds, then 8 digest
// transfers; the input is not ready from close until word 7
// synchronous active-low reset loads the initial hash values and clears the
// bit count; the block is ready right after reset
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// streaming sha-256: byte input, padding sequencer, eight-word digest output
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha_pkg::t_in_item   i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output sha_pkg::t_out_item  o_out
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    t_words8     r_chain;
    logic [63:0] r_msg_bits;
    logic [63:0] r_len;
    logic [5:0]  r_fill;
    logic [23:0] r_acc;
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    logic        r_closing;
    logic        r_mark_pend;
    logic        r_len_phase;
    logic        r_pad_done;

    logic        in_xfer, out_xfer;
    logic        byte_wr;
    logic        data_wr;
    logic [7:0]  byte_val;
    logic [7:0]  pad_byte;
    logic [63:0] len_shift;
    t_core_ctrl  core_ctrl;
    t_words8     vars;
    logic        round_end;
    logic        digest_end;
    logic        restarted;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    // padding byte: marker, zeros, then big-endian bit length
    always_comb begin
        len_shift = r_len << {r_fill[2:0], 3'b000};
        if (r_mark_pend) begin
            pad_byte = PAD_MARK;
        end else if (r_len_phase) begin
            pad_byte = len_shift[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // sequencer next state and controls
    always_comb begin
        n_state   = r_state;
        byte_wr   = 1'b0;
        data_wr   = 1'b0;
        byte_val  = i_in.data_byte;
        core_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_in.byte_present) begin
                        byte_wr = 1'b1;
                        data_wr = 1'b1;
                    end
                    if (i_in.byte_present && r_fill == FILL_LAST) begin
                        n_state = S_ROUND;
                    end else if (i_in.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                byte_wr  = 1'b1;
                byte_val = pad_byte;
                if (r_fill == FILL_LAST) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                core_ctrl.round = 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_closing) begin
                    n_state = S_IDLE;
                end else if (r_pad_done) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (i_ready && r_idx == WORD_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        core_ctrl.load = (n_state == S_ROUND) && (r_state != S_ROUND);
        core_ctrl.push = byte_wr && (r_fill[1:0] == 2'd3);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // byte fill, bit count, padding flags, chain value, round and word counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain     <= HASH_INIT;
            r_msg_bits  <= '0;
            r_fill      <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_closing   <= 1'b0;
            r_mark_pend <= 1'b0;
            r_len_phase <= 1'b0;
            r_pad_done  <= 1'b0;
        end else begin
            if (byte_wr) begin
                r_fill <= r_fill + 6'd1;
            end
            if (data_wr) begin
                r_msg_bits <= r_msg_bits + 64'd8;
            end
            // start of a new item
            if (in_xfer) begin
                r_closing   <= i_in.end_of_message;
                r_mark_pend <= 1'b1;
                r_len_phase <= 1'b0;
                r_pad_done  <= 1'b0;
            end
            // padding progress
            if (r_state == S_PAD) begin
                r_mark_pend <= 1'b0;
                if (r_fill == FILL_LEN) begin
                    r_len_phase <= 1'b1;
                end
                if (r_len_phase && r_fill == FILL_LAST) begin
                    r_pad_done <= 1'b1;
                end
            end
            if (r_state == S_ROUND) begin
                r_round <= r_round + 6'd1;
            end
            // fold working variables into the chain value
            if (r_state == S_FINISH) begin
                for (int j = 0; j < 8; j++) begin
                    r_chain[j] <= r_chain[j] + vars[j];
                end
            end
            // digest words out, then back to the initial state
            if (out_xfer) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == WORD_LAST) begin
                    r_chain    <= HASH_INIT;
                    r_msg_bits <= '0;
                    r_closing  <= 1'b0;
                end
            end
        end
    end

    // byte packing and latched message length
    always_ff @(posedge i_clk) begin
        if (byte_wr) begin
            r_acc <= {r_acc[15:0], byte_val};
        end
        if (in_xfer) begin
            r_len <= r_msg_bits + (i_in.byte_present ? 64'd8 : 64'd0);
        end
    end

    sha_core u_core (
        .i_clk       (i_clk),
        .i_ctrl      (core_ctrl),
        .i_push_word ({r_acc, byte_val}),
        .i_k         (ROUND_K[r_round]),
        .i_chain     (r_chain),
        .o_vars      (vars)
    );

    // handshakes and digest output
    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = (r_state == S_OUT);
    assign o_out.digest_word = r_chain[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == WORD_LAST);

    // check terms
    assign round_end  = (r_state == S_ROUND) && (r_round == ROUND_LAST);
    assign digest_end = out_xfer && (r_idx == WORD_LAST);
    assign restarted  = (r_state == S_IDLE) && (r_msg_bits == 64'd0);

    // checks
    `SHA_ASSERT_ALWAYS(a_no_overlap, i_clk, i_rst_n, !(o_ready && o_valid))
    `SHA_ASSERT_SAME(a_round_block_full, i_clk, i_rst_n, r_state == S_ROUND, r_fill == 6'd0)
    `SHA_ASSERT_NEXT(a_round_end, i_clk, i_rst_n, round_end, r_state == S_FINISH)
    `SHA_ASSERT_NEXT(a_digest_restart, i_clk, i_rst_n, digest_end, restarted)

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// streaming sha-256 hasher: random byte streams, padding edges, digest checks
// ----------------------------------------------------------------------------
// a predictor in the driver hashes every accepted input transfer and, on a
// close, queues the eight expected digest words; the monitor compares each output transfer
// against the oldest queued word, field by field
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::*;

    localparam int          WORDS_PER_DIGEST = 8;
    localparam int          HOLD_CYCLES      = 800;
    localparam int          ITEM_TARGET      = 320;
    localparam logic [7:0]  PAD_BYTE         = 8'h80;

    // sha-256 round constants and initial chain value
    localparam logic [0:63][31:0] RND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [0:7][31:0] CHAIN_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // one pending input transfer with its lead-in gap and drain flag
    typedef struct packed {
        t_in_item   item;
        logic [3:0] gap;
        logic       drain;
    } t_stim;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_item   i_in    = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_item  o_out;

    // predictor state
    logic [31:0] chain_h [8];
    logic [7:0]  blk_buf [64];
    logic [63:0] msg_bits;

    t_stim      pending_q [$];
    t_out_item  digest_q [$];
    int         words_due  = 0;
    int         words_seen = 0;
    int         fail_count = 0;
    int         gap_cnt    = 0;
    int         stall_cnt  = 0;
    logic       hold_off   = 1'b0;
    logic       tx_gaps_on = 1'b1;
    logic       rx_gaps_on = 1'b1;

    sha256_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of the block buffer into the chain value
    task automatic compress_buf();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        int          t;
        for (t = 0; t < 16; t++) begin
            w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
        end
        for (t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (t = 0; t < 8; t++) v[t] = chain_h[t];
        for (t = 0; t < 64; t++) begin
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[t] + w[t];
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (t = 0; t < 8; t++) chain_h[t] = chain_h[t] + v[t];
    endtask

    // absorb one input transfer; a close pads, finishes and queues the digest
    task automatic hash_item(input t_in_item it);
        int        fill;
        int        j;
        t_out_item word;
        if (it.byte_present) begin
            fill = int'(msg_bits[8:3]);
            blk_buf[fill] = it.data_byte;
            msg_bits = msg_bits + 64'd8;
            if (fill == 63) compress_buf();
        end
        if (it.end_of_message) begin
            fill = int'(msg_bits[8:3]);
            blk_buf[fill] = PAD_BYTE;
            fill++;
            // length field no longer fits: pad out and compress an extra block
            if (fill > 56) begin
                for (j = fill; j < 64; j++) blk_buf[j] = 8'h00;
                compress_buf();
                fill = 0;
            end
            for (j = fill; j < 56; j++) blk_buf[j] = 8'h00;
            for (j = 0; j < 8; j++) blk_buf[63-j] = msg_bits[8*j +: 8];
            compress_buf();
            for (j = 0; j < WORDS_PER_DIGEST; j++) begin
                word.digest_word = chain_h[j];
                word.word_index  = 3'(j);
                word.last_word   = (j == WORDS_PER_DIGEST - 1);
                digest_q.push_back(word);
            end
            for (j = 0; j < 8; j++) chain_h[j] = CHAIN_IV[j];
            msg_bits = '0;
        end
    endtask

    task automatic queue_item(input logic [7:0] d, input logic bp, input logic eom,
                              input logic drn);
        t_stim s;
        if ($urandom_range(0, 29) == 0) tx_gaps_on = !tx_gaps_on;
        s.item.data_byte      = d;
        s.item.byte_present   = bp;
        s.item.end_of_message = eom;
        s.gap   = tx_gaps_on ? 4'($urandom_range(0, 13)) : 4'd0;
        s.drain = drn;
        pending_q.push_back(s);
    endtask

    // driver: predicts on every accepted transfer, then offers the next item
    always @(posedge i_clk) begin : drive_proc
        logic  took;
        logic  free;
        int    due_now;
        t_stim nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            took    = i_valid && o_ready;
            free    = took || !i_valid;
            due_now = words_due;
            if (took) begin
                hash_item(i_in);
                if (i_in.end_of_message) begin
                    due_now = words_due + WORDS_PER_DIGEST;
                    words_due <= due_now;
                end
            end
            if (free) begin
                if (pending_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (gap_cnt < int'(pending_q[0].gap) ||
                             (pending_q[0].drain && words_seen != due_now)) begin
                    i_valid <= 1'b0;
                    gap_cnt <= gap_cnt + 1;
                end else begin
                    nxt = pending_q.pop_front();
                    i_in    <= nxt.item;
                    i_valid <= 1'b1;
                    gap_cnt <= 0;
                end
            end
        end
    end

    // monitor: checks each output transfer and paces the ready line
    always @(posedge i_clk) begin : watch_proc
        t_out_item want;
        int        w;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            stall_cnt <= 0;
        end else if (o_valid && i_ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digest word %h index %0d",
                                          o_out.digest_word, o_out.word_index));
            end else begin
                want = digest_q.pop_front();
                if (o_out.digest_word !== want.digest_word)
                    report_mismatch($sformatf("digest_word %h, want %h (index %0d)",
                                              o_out.digest_word, want.digest_word,
                                              want.word_index));
                if (o_out.word_index !== want.word_index)
                    report_mismatch($sformatf("word_index %0d, want %0d",
                                              o_out.word_index, want.word_index));
                if (o_out.last_word !== want.last_word)
                    report_mismatch($sformatf("last_word %b, want %b (index %0d)",
                                              o_out.last_word, want.last_word,
                                              want.word_index));
            end
            words_seen <= words_seen + 1;
            if ($urandom_range(0, 29) == 0) rx_gaps_on = !rx_gaps_on;
            w = rx_gaps_on ? $urandom_range(0, 13) : 0;
            if (w != 0 || hold_off) begin
                i_ready   <= 1'b0;
                stall_cnt <= w;
            end
        end else if (i_ready) begin
            if (hold_off) i_ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
        end else if (!hold_off) begin
            i_ready <= 1'b1;
        end
    end

    // long receiver hold-off while a digest is pending, so the input backs up
    initial begin
        while (!(words_seen >= 2 * WORDS_PER_DIGEST && words_due > words_seen))
            @(negedge i_clk);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int   j;
        int   k;
        int   len;
        int   r;
        int   item_total;
        logic merge;
        logic drn;

        for (j = 0; j < 8; j++) chain_h[j] = CHAIN_IV[j];
        for (j = 0; j < 64; j++) blk_buf[j] = 8'h00;
        msg_bits = '0;

        // directed: idle item, empty message, single extreme bytes, "abc"
        queue_item(8'hff, 1'b0, 1'b0, 1'b0);
        queue_item(8'ha5, 1'b0, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1, 1'b0);
        queue_item(8'hff, 1'b1, 1'b0, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b1, 1'b0);
        queue_item(8'h61, 1'b1, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1, 1'b0);
        // idle item inside a message, then an empty message right after
        queue_item(8'h12, 1'b1, 1'b0, 1'b0);
        queue_item(8'hff, 1'b0, 1'b0, 1'b0);
        queue_item(8'h34, 1'b1, 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1, 1'b0);

        // random messages, lengths biased toward small and block edges
        item_total = 0;
        drn = 1'b1;
        while (item_total < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                r = $urandom_range(1, 3);
                for (k = 0; k < r; k++) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                len = $urandom_range(0, 8);
            end else if (r < 72) begin
                len = $urandom_range(9, 40);
            end else begin
                case ($urandom_range(0, 7))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    default: len = 120;
                endcase
            end
            merge = (len > 0) && ($urandom_range(0, 1) == 1);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 19) == 0)
                    queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
                queue_item(8'($urandom_range(0, 255)), 1'b1, merge && (k == len - 1),
                           drn && (k == 0));
            end
            if (!merge) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drn && (len == 0));
            item_total += len + (merge ? 0 : 1);
            drn = ($urandom_range(0, 7) == 0);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every transfer in, every digest word out, then settle
        @(negedge i_clk);
        while (pending_q.size() != 0 || i_valid) @(negedge i_clk);
        while (words_seen < words_due) @(negedge i_clk);
        repeat (300) @(posedge i_clk);
        if (digest_q.size() != 0)
            report_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
